[design/decaying_level_duty_dither_macros.svh]
// Assertion macros used by the design files (dld_core).
`ifndef DECAYING_LEVEL_DUTY_DITHER_MACROS_SVH
`define DECAYING_LEVEL_DUTY_DITHER_MACROS_SVH

`ifndef SYNTHESIS
// Check a property at each rising edge, skipped while reset is high.
`define DLD_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check a property at each rising edge, reset included.
`define DLD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define DLD_ASSERT(lbl, clk, rst, prop, msg)
`define DLD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[design/dld_pkg.sv]
// Package: widths, constants, register indexes and word types of the dither block.
package dld_pkg;

  localparam int FRAC_BITS = 16;
  localparam int LEVEL_W   = FRAC_BITS + 1;
  localparam int PROD_W    = LEVEL_W + FRAC_BITS;
  localparam int CFG_IDX_W = 2;

  localparam logic [LEVEL_W-1:0] ONE_VAL = LEVEL_W'(1) << FRAC_BITS;

  // 0.94 and 0.02 rounded to the fixed-point grid
  localparam logic [FRAC_BITS-1:0] DECAY_RESET =
    FRAC_BITS'(((94 << FRAC_BITS) + 50) / 100);
  localparam logic [LEVEL_W-1:0] FLOOR_RESET =
    LEVEL_W'(((2 << FRAC_BITS) + 50) / 100);

  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_FACTOR    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_THRESHOLD = CFG_IDX_W'(1);

  localparam logic MODE_ADD  = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [LEVEL_W-1:0] amount;
    logic               pak_present;
  } dld_in_t;

  typedef struct packed {
    logic               drive_on;
    logic               command_valid;
    logic [LEVEL_W-1:0] level_now;
  } dld_out_t;

endpackage

[design/dld_in_stage.sv]
// Input register: holds one accepted word until the core takes it.
module dld_in_stage
  import dld_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  dld_in_t in_data,
  output logic    s1_valid,
  input  logic    s1_ready,
  output dld_in_t s1_data
);

  assign in_ready = !s1_valid || s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data <= in_data;
    end
  end

endmodule

[design/dld_core.sv]
// Core: config registers, level/accumulator/motor state and the per-word update.
`include "decaying_level_duty_dither_macros.svh"

module dld_core
  import dld_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LEVEL_W-1:0]   cfg_wr_data,
  input  logic                 s1_valid,
  output logic                 s1_ready,
  input  dld_in_t              s1_data,
  output logic                 res_valid,
  input  logic                 res_ready,
  output dld_out_t             res_data
);

  logic [FRAC_BITS-1:0] decay_factor;
  logic [LEVEL_W-1:0]   floor_threshold;
  logic [LEVEL_W-1:0]   energy_level;
  logic [FRAC_BITS-1:0] dither_error;
  logic                 motor_state;

  logic [LEVEL_W-1:0]   energy_level_next;
  logic [FRAC_BITS-1:0] dither_error_next;
  logic                 motor_state_next;
  logic                 cmd;

  logic                 fire;
  logic [LEVEL_W:0]     add_sum;
  logic [PROD_W-1:0]    prod;
  logic [LEVEL_W-1:0]   decayed;
  logic [LEVEL_W-1:0]   floored;
  logic [LEVEL_W:0]     acc_sum;
  logic                 want;

  assign s1_ready  = res_ready;
  assign res_valid = s1_valid;
  assign fire      = s1_valid && res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      decay_factor    <= DECAY_RESET;
      floor_threshold <= FLOOR_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_DECAY_FACTOR:    decay_factor    <= cfg_wr_data[FRAC_BITS-1:0];
        CFG_FLOOR_THRESHOLD: floor_threshold <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    add_sum = {1'b0, energy_level} + {1'b0, s1_data.amount};
    prod    = PROD_W'(energy_level) * PROD_W'(decay_factor);
    decayed = prod[PROD_W-1:FRAC_BITS];
    floored = (decayed < floor_threshold) ? '0 : decayed;
    acc_sum = {1'b0, LEVEL_W'(dither_error)} + {1'b0, floored};
    // sum stays below two, so dropping the one bit subtracts one
    want    = acc_sum >= {1'b0, ONE_VAL};

    energy_level_next = energy_level;
    dither_error_next = dither_error;
    motor_state_next  = motor_state;
    cmd               = 1'b0;

    if (s1_data.mode == MODE_ADD) begin
      // saturate at one
      energy_level_next = (add_sum > {1'b0, ONE_VAL}) ? ONE_VAL : add_sum[LEVEL_W-1:0];
    end else if (!s1_data.pak_present) begin
      energy_level_next = '0;
      dither_error_next = '0;
      motor_state_next  = 1'b0;
      cmd               = motor_state;
    end else begin
      energy_level_next = floored;
      dither_error_next = acc_sum[FRAC_BITS-1:0];
      motor_state_next  = want;
      cmd               = want != motor_state;
    end

    res_data.drive_on      = motor_state_next;
    res_data.command_valid = cmd;
    res_data.level_now     = energy_level_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      energy_level <= '0;
      dither_error <= '0;
      motor_state  <= 1'b0;
    end else if (fire) begin
      energy_level <= energy_level_next;
      dither_error <= dither_error_next;
      motor_state  <= motor_state_next;
    end
  end

  `DLD_ASSERT(a_level_le_one, clk, rst, energy_level <= ONE_VAL, "level above one")
  `DLD_ASSERT(a_cmd_on_change, clk, rst,
    fire |=> ((motor_state != $past(motor_state)) == $past(res_data.command_valid)),
    "command flag does not match motor state change")
  `DLD_ASSERT(a_add_keeps_motor, clk, rst,
    (fire && s1_data.mode == MODE_ADD) |=> $stable(motor_state),
    "add word changed motor state")
  `DLD_ASSERT(a_absent_clears, clk, rst,
    (fire && s1_data.mode == MODE_TICK && !s1_data.pak_present) |=>
      (energy_level == '0 && dither_error == '0 && !motor_state),
    "tick without pak did not clear state")

endmodule

[design/dld_out_stage.sv]
// Output register: holds a finished result word until the consumer takes it.
module dld_out_stage
  import dld_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     res_valid,
  output logic     res_ready,
  input  dld_out_t res_data,
  output logic     out_valid,
  input  logic     out_ready,
  output dld_out_t out_data
);

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_data <= res_data;
    end
  end

endmodule

[design/decaying_level_duty_dither.sv]
// A word accepted into the input register passes through the core into the output register.
// Throughput: one word per cycle while out_ready is high; the decay multiply and accumulate sit
// in one stage between the input and output registers, state updated as the word passes.
// Reset (synchronous, rst high): level, accumulator and motor state cleared, decay and
// floor registers back to 0.94 and 0.02, both registers empty.
module decaying_level_duty_dither
  import dld_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LEVEL_W-1:0]   cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  dld_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output dld_out_t             out_data
);

  logic     s1_valid;
  logic     s1_ready;
  dld_in_t  s1_data;
  logic     res_valid;
  logic     res_ready;
  dld_out_t res_data;

  dld_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1_data  (s1_data)
  );

  dld_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .s1_valid    (s1_valid),
    .s1_ready    (s1_ready),
    .s1_data     (s1_data),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res_data    (res_data)
  );

  dld_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
